>>> rtl/prot_pkg.sv
// prot_pkg: shared types and constants of the point rotation block
// holds the coefficient sequencer states, register indexes, cordic table and q2.30 helpers
// no dependencies
package prot_pkg;

   // coefficient sequencer states
   typedef enum logic [6:0] {
      SEQ_IDLE = 7'b0000001,
      SEQ_NORM = 7'b0000010,
      SEQ_RSQ  = 7'b0000100,
      SEQ_UNIT = 7'b0001000,
      SEQ_CORD = 7'b0010000,
      SEQ_EH   = 7'b0100000,
      SEQ_A1   = 7'b1000000
   } seq_state_type;

   // register indexes
   localparam logic [2:0] REG_ANGLE    = 3'd0;
   localparam logic [2:0] REG_CENTER_X = 3'd1;
   localparam logic [2:0] REG_CENTER_Y = 3'd2;
   localparam logic [2:0] REG_CENTER_Z = 3'd3;
   localparam logic [2:0] REG_AXIS_X   = 3'd4;
   localparam logic [2:0] REG_AXIS_Y   = 3'd5;
   localparam logic [2:0] REG_AXIS_Z   = 3'd6;

   // q2.30 constants
   localparam logic signed [31:0] Q30_ONE         = 32'sd1073741824;
   localparam logic signed [33:0] CORDIC_GAIN_INV = 34'sd652032874;
   localparam logic [33:0]        RSQRT_SEED      = 34'd805306368;
   localparam logic [34:0]        RSQRT_THREE     = 35'd3221225472;
   localparam logic [5:0]         RSQRT_LAST      = 6'd6;

   // arctangent of 2^-i, 2^32 per turn
   function automatic logic [29:0] atan_entry(input logic [4:0] i);
      logic [29:0] v;
      unique case (i)
         5'd0:  v = 30'd536870912;
         5'd1:  v = 30'd316933406;
         5'd2:  v = 30'd167458907;
         5'd3:  v = 30'd85004756;
         5'd4:  v = 30'd42667331;
         5'd5:  v = 30'd21354465;
         5'd6:  v = 30'd10679838;
         5'd7:  v = 30'd5340245;
         5'd8:  v = 30'd2670163;
         5'd9:  v = 30'd1335087;
         5'd10: v = 30'd667544;
         5'd11: v = 30'd333772;
         5'd12: v = 30'd166886;
         5'd13: v = 30'd83443;
         5'd14: v = 30'd41722;
         5'd15: v = 30'd20861;
         5'd16: v = 30'd10430;
         5'd17: v = 30'd5215;
         5'd18: v = 30'd2608;
         5'd19: v = 30'd1304;
         5'd20: v = 30'd652;
         5'd21: v = 30'd326;
         5'd22: v = 30'd163;
         5'd23: v = 30'd81;
         5'd24: v = 30'd41;
         5'd25: v = 30'd20;
         5'd26: v = 30'd10;
         5'd27: v = 30'd5;
         5'd28: v = 30'd3;
         5'd29: v = 30'd1;
         5'd30: v = 30'd1;
         default: v = 30'd0;
      endcase
      return v;
   endfunction

   // clamp to [-1.0, 1.0] in q2.30
   function automatic logic signed [31:0] clamp_q30(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > 64'(Q30_ONE)) begin
         r = Q30_ONE;
      end else if (v < -64'(Q30_ONE)) begin
         r = -Q30_ONE;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

>>> rtl/point_rotation_about_axis.sv
// point_rotation_about_axis: rotates q16.16 points about an axis through a center
// holds the coefficient sequencer (rsqrt, cordic) and the five stage point pipeline
// depends on prot_pkg
//
//   channel | direction | handshake            | beat
//   req     | in        | req_valid/req_stall  | point x, y, z and last flag
//   rsp     | out       | rsp_valid/rsp_stall  | rotated point, null_axis, last flag
//   csr     | in        | csr_we               | register index and write data
//
// one point per cycle while the sequencer is idle and the output is not stalled.
// after reset and after every register write the sequencer rebuilds the coefficients
// in its normalize (k up to 15 shifts), rsqrt, unit, cordic, e and a1 steps;
// req_stall is high meanwhile.
// reset is synchronous and clears control state and the registers to their defaults.
// a stalled output freezes the whole pipeline; no beat is lost or repeated.
module point_rotation_about_axis #(
   parameter int COORD_BITS   = 32,
   parameter int CORDIC_STEPS = 24
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [COORD_BITS-1:0] req_px_in,
   input  logic signed [COORD_BITS-1:0] req_py_in,
   input  logic signed [COORD_BITS-1:0] req_pz_in,
   input  logic                         req_last_in,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [COORD_BITS-1:0] rsp_px_out,
   output logic signed [COORD_BITS-1:0] rsp_py_out,
   output logic signed [COORD_BITS-1:0] rsp_pz_out,
   output logic                         rsp_null_axis,
   output logic                         rsp_last_out,
   input  logic                         csr_we,
   input  logic [2:0]                   csr_index,
   input  logic [31:0]                  csr_wdata
);

   localparam int CW = (COORD_BITS > 32) ? COORD_BITS : 32;
   localparam int PW = CW + 10;
   localparam logic signed [PW-1:0] SAT_HI = PW'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
   localparam logic signed [PW-1:0] SAT_LO = -SAT_HI - PW'(1);
   localparam logic [5:0] CORD_LAST = 6'(CORDIC_STEPS - 1);

   // floor(a * b / 2^30) on the full product
   function automatic logic signed [PW-1:0] mq(input logic signed [PW-1:0] a,
                                              input logic signed [31:0] b);
      logic signed [PW+31:0] pr;
      pr = (PW+32)'(a) * (PW+32)'(b);
      return pr[PW+29:30];
   endfunction

   // configuration registers
   logic [15:0]        angle_ff;
   logic signed [31:0] center_ff [3];
   logic signed [15:0] axis_ff [3];
   logic               null_axis;

   always_ff @(posedge clock) begin
      if (reset) begin
         angle_ff     <= '0;
         center_ff[0] <= '0;
         center_ff[1] <= '0;
         center_ff[2] <= '0;
         axis_ff[0]   <= '0;
         axis_ff[1]   <= '0;
         axis_ff[2]   <= 16'sd1;
      end else if (csr_we) begin
         unique case (csr_index)
            prot_pkg::REG_ANGLE:    angle_ff     <= csr_wdata[15:0];
            prot_pkg::REG_CENTER_X: center_ff[0] <= csr_wdata;
            prot_pkg::REG_CENTER_Y: center_ff[1] <= csr_wdata;
            prot_pkg::REG_CENTER_Z: center_ff[2] <= csr_wdata;
            prot_pkg::REG_AXIS_X:   axis_ff[0]   <= csr_wdata[15:0];
            prot_pkg::REG_AXIS_Y:   axis_ff[1]   <= csr_wdata[15:0];
            prot_pkg::REG_AXIS_Z:   axis_ff[2]   <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   assign null_axis = (axis_ff[0] == '0) && (axis_ff[1] == '0) && (axis_ff[2] == '0);

   // coefficient sequencer registers
   prot_pkg::seq_state_type state_ff, state_in;
   logic               dirty_ff, dirty_in;
   logic [2:0]         sub_ff, sub_in;
   logic [5:0]         iter_ff, iter_in;
   logic [3:0]         k_ff, k_in;
   logic [31:0]        m_ff, m_in;
   logic [33:0]        y_ff, y_in;
   logic [33:0]        y2_ff, y2_in;
   logic [33:0]        t_ff, t_in;
   logic signed [31:0] u_ff [3];
   logic signed [31:0] u_in [3];
   logic signed [31:0] e_ff [3];
   logic signed [31:0] e_in [3];
   logic signed [63:0] acc_ff, acc_in;
   logic signed [33:0] cx_ff [2];
   logic signed [33:0] cx_in [2];
   logic signed [33:0] cy_ff [2];
   logic signed [33:0] cy_in [2];
   logic signed [33:0] cz_ff [2];
   logic signed [33:0] cz_in [2];
   logic               neg_ff [2];
   logic               neg_in [2];
   logic signed [31:0] coef_ff [8];
   logic signed [31:0] coef_in [8];

   // cordic start values for the half and the full angle
   logic [31:0]        phase [2];
   logic [31:0]        fold [2];
   logic               fold_neg [2];
   logic signed [31:0] c0_fin, h_fin, st_fin;
   logic               busy;

   always_comb begin
      phase[0] = {1'b0, angle_ff, 15'd0};
      phase[1] = {angle_ff, 16'd0};
      for (int i = 0; i < 2; i++) begin
         logic [31:0] q;
         q           = phase[i] + 32'h4000_0000;
         fold_neg[i] = q[31];
         fold[i]     = q[31] ? (phase[i] - 32'h8000_0000) : phase[i];
      end
   end

   // final cordic outputs, clamped and sign corrected
   always_comb begin
      logic signed [31:0] cc0, cs0, cs1;
      cc0    = prot_pkg::clamp_q30(64'(cx_ff[0]));
      cs0    = prot_pkg::clamp_q30(64'(cy_ff[0]));
      cs1    = prot_pkg::clamp_q30(64'(cy_ff[1]));
      c0_fin = neg_ff[0] ? -cc0 : cc0;
      h_fin  = neg_ff[0] ? -cs0 : cs0;
      st_fin = neg_ff[1] ? -cs1 : cs1;
   end

   // sequencer next state
   always_comb begin
      logic [67:0]        p68;
      logic [65:0]        p66;
      logic signed [34:0] f_s;
      logic [32:0]        f_u;
      logic signed [50:0] up;
      logic signed [50:0] us;
      logic signed [63:0] pe;
      logic [1:0]         ls;
      logic               go_cord;
      state_in = state_ff;
      dirty_in = dirty_ff;
      sub_in   = sub_ff;
      iter_in  = iter_ff;
      k_in     = k_ff;
      m_in     = m_ff;
      y_in     = y_ff;
      y2_in    = y2_ff;
      t_in     = t_ff;
      acc_in   = acc_ff;
      u_in     = u_ff;
      e_in     = e_ff;
      cx_in    = cx_ff;
      cy_in    = cy_ff;
      cz_in    = cz_ff;
      neg_in   = neg_ff;
      coef_in  = coef_ff;
      go_cord  = 1'b0;
      p68      = '0;
      p66      = '0;
      f_s      = '0;
      f_u      = '0;
      up       = '0;
      us       = '0;
      pe       = '0;
      ls       = sub_ff[1:0];
      if (csr_we) begin
         if (csr_index <= prot_pkg::REG_AXIS_Z) begin
            state_in = prot_pkg::SEQ_IDLE;
            dirty_in = 1'b1;
         end
      end else begin
         unique case (state_ff)
            prot_pkg::SEQ_IDLE: begin
               if (dirty_ff) begin
                  dirty_in = 1'b0;
                  m_in = 32'(32'(axis_ff[0]) * 32'(axis_ff[0])
                         + 32'(axis_ff[1]) * 32'(axis_ff[1])
                         + 32'(axis_ff[2]) * 32'(axis_ff[2]));
                  k_in     = '0;
                  state_in = prot_pkg::SEQ_NORM;
               end
            end
            // scale the squared norm into [1, 4) by two bits a step
            prot_pkg::SEQ_NORM: begin
               if (null_axis) begin
                  u_in[0] = '0;
                  u_in[1] = '0;
                  u_in[2] = prot_pkg::Q30_ONE;
                  go_cord = 1'b1;
               end else if (m_ff[31:30] == 2'b00) begin
                  m_in = {m_ff[29:0], 2'b00};
                  k_in = k_ff + 4'd1;
               end else begin
                  y_in     = prot_pkg::RSQRT_SEED;
                  sub_in   = '0;
                  iter_in  = '0;
                  state_in = prot_pkg::SEQ_RSQ;
               end
            end
            // newton steps for the reciprocal square root
            prot_pkg::SEQ_RSQ: begin
               unique case (sub_ff)
                  3'd0: begin
                     p68    = 68'(y_ff) * 68'(y_ff);
                     y2_in  = p68[63:30];
                     sub_in = 3'd1;
                  end
                  3'd1: begin
                     p66    = 66'(m_ff) * 66'(y2_ff);
                     t_in   = p66[63:30];
                     sub_in = 3'd2;
                  end
                  default: begin
                     f_s    = $signed(prot_pkg::RSQRT_THREE) - $signed({1'b0, t_ff});
                     f_u    = f_s[34] ? 33'd0 : f_s[32:0];
                     p68    = 68'(y_ff) * 68'(f_u);
                     y_in   = p68[64:31];
                     sub_in = 3'd0;
                     iter_in = iter_ff + 6'd1;
                     if (iter_ff == prot_pkg::RSQRT_LAST) begin
                        iter_in  = '0;
                        state_in = prot_pkg::SEQ_UNIT;
                     end
                  end
               endcase
            end
            // unit axis components, one per cycle
            prot_pkg::SEQ_UNIT: begin
               up = 51'(axis_ff[ls]) * $signed({17'd0, y_ff});
               us = up >>> (4'd15 - k_ff);
               u_in[ls] = prot_pkg::clamp_q30(64'(us));
               sub_in = sub_ff + 3'd1;
               if (ls == 2'd2) begin
                  go_cord = 1'b1;
               end
            end
            // both cordics, one iteration per cycle
            prot_pkg::SEQ_CORD: begin
               for (int i = 0; i < 2; i++) begin
                  if (!cz_ff[i][33]) begin
                     cx_in[i] = cx_ff[i] - (cy_ff[i] >>> iter_ff[4:0]);
                     cy_in[i] = cy_ff[i] + (cx_ff[i] >>> iter_ff[4:0]);
                     cz_in[i] = cz_ff[i] - 34'(prot_pkg::atan_entry(iter_ff[4:0]));
                  end else begin
                     cx_in[i] = cx_ff[i] + (cy_ff[i] >>> iter_ff[4:0]);
                     cy_in[i] = cy_ff[i] - (cx_ff[i] >>> iter_ff[4:0]);
                     cz_in[i] = cz_ff[i] + 34'(prot_pkg::atan_entry(iter_ff[4:0]));
                  end
               end
               iter_in = iter_ff + 6'd1;
               if (iter_ff == CORD_LAST) begin
                  sub_in   = '0;
                  state_in = prot_pkg::SEQ_EH;
               end
            end
            // e = -u * sin(t/2)
            prot_pkg::SEQ_EH: begin
               pe = 64'(u_ff[ls]) * 64'(h_fin);
               e_in[ls] = -pe[61:30];
               sub_in = sub_ff + 3'd1;
               if (ls == 2'd2) begin
                  sub_in   = '0;
                  state_in = prot_pkg::SEQ_A1;
               end
            end
            // a1 = cos(t/2)^2 - |e|^2, then commit
            prot_pkg::SEQ_A1: begin
               unique case (sub_ff)
                  3'd0: begin
                     acc_in = 64'(c0_fin) * 64'(c0_fin);
                     sub_in = 3'd1;
                  end
                  3'd1, 3'd2, 3'd3: begin
                     ls     = sub_ff[1:0] - 2'd1;
                     acc_in = acc_ff - 64'(e_ff[ls]) * 64'(e_ff[ls]);
                     sub_in = sub_ff + 3'd1;
                  end
                  default: begin
                     pe         = acc_ff >>> 30;
                     coef_in[0] = u_ff[0];
                     coef_in[1] = u_ff[1];
                     coef_in[2] = u_ff[2];
                     coef_in[3] = pe[31:0];
                     coef_in[4] = e_ff[0];
                     coef_in[5] = e_ff[1];
                     coef_in[6] = e_ff[2];
                     coef_in[7] = st_fin;
                     sub_in     = '0;
                     state_in   = prot_pkg::SEQ_IDLE;
                  end
               endcase
            end
            default: state_in = prot_pkg::SEQ_IDLE;
         endcase
         if (go_cord) begin
            for (int i = 0; i < 2; i++) begin
               neg_in[i] = fold_neg[i];
               cx_in[i]  = prot_pkg::CORDIC_GAIN_INV;
               cy_in[i]  = '0;
               cz_in[i]  = 34'($signed(fold[i]));
            end
            iter_in  = '0;
            state_in = prot_pkg::SEQ_CORD;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= prot_pkg::SEQ_IDLE;
         dirty_ff   <= 1'b1;
         sub_ff     <= '0;
         iter_ff    <= '0;
         coef_ff[0] <= '0;
         coef_ff[1] <= '0;
         coef_ff[2] <= prot_pkg::Q30_ONE;
         coef_ff[3] <= prot_pkg::Q30_ONE;
         coef_ff[4] <= '0;
         coef_ff[5] <= '0;
         coef_ff[6] <= '0;
         coef_ff[7] <= '0;
      end else begin
         state_ff <= state_in;
         dirty_ff <= dirty_in;
         sub_ff   <= sub_in;
         iter_ff  <= iter_in;
         coef_ff  <= coef_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff   <= k_in;
      m_ff   <= m_in;
      y_ff   <= y_in;
      y2_ff  <= y2_in;
      t_ff   <= t_in;
      acc_ff <= acc_in;
      u_ff   <= u_in;
      e_ff   <= e_in;
      cx_ff  <= cx_in;
      cy_ff  <= cy_in;
      cz_ff  <= cz_in;
      neg_ff <= neg_in;
   end

   // handshake: the whole pipe moves unless the output beat is held
   logic adv;
   logic accept;
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;

   assign busy      = dirty_ff || (state_ff != prot_pkg::SEQ_IDLE);
   assign adv       = !(v5_ff && rsp_stall);
   assign req_stall = busy || !adv;
   assign accept    = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= accept;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   // point pipeline payload
   logic signed [COORD_BITS-1:0] p_in [3];
   logic signed [COORD_BITS-1:0] p1_ff [3];
   logic signed [COORD_BITS-1:0] p2_ff [3];
   logic signed [COORD_BITS-1:0] p3_ff [3];
   logic signed [COORD_BITS-1:0] p4_ff [3];
   logic signed [COORD_BITS-1:0] o_ff [3];
   logic signed [COORD_BITS-1:0] o_in [3];
   logic [4:0] last_ff, nul_ff;
   logic signed [PW-1:0] r_ff [3];
   logic signed [PW-1:0] r_in [3];
   logic signed [PW-1:0] ra2_ff [3];
   logic signed [PW-1:0] ra2_in [3];
   logic signed [PW-1:0] re_ff [3];
   logic signed [PW-1:0] re_in [3];
   logic signed [PW-1:0] pj_ff [3];
   logic signed [PW-1:0] pj_in [3];
   logic signed [PW-1:0] pk_ff [3];
   logic signed [PW-1:0] pk_in [3];
   logic signed [PW-1:0] ra3_ff [3];
   logic signed [PW-1:0] a2_ff, a2_in;
   logic signed [PW-1:0] cr_ff [3];
   logic signed [PW-1:0] cr_in [3];
   logic signed [PW-1:0] ra4_ff [3];
   logic signed [PW-1:0] ae_ff [3];
   logic signed [PW-1:0] ae_in [3];
   logic signed [PW-1:0] cs_ff [3];
   logic signed [PW-1:0] cs_in [3];

   assign p_in[0] = req_px_in;
   assign p_in[1] = req_py_in;
   assign p_in[2] = req_pz_in;

   // per lane arithmetic of all stages
   always_comb begin
      int j, k;
      logic signed [PW-1:0] sum;
      a2_in = re_ff[0] + re_ff[1] + re_ff[2];
      for (int i = 0; i < 3; i++) begin
         j = (i == 2) ? 0 : i + 1;
         k = (i == 0) ? 2 : i - 1;
         // translate to the center
         r_in[i]   = PW'(p_in[i]) - PW'(center_ff[i]);
         // first products
         ra2_in[i] = mq(r_ff[i], coef_ff[3]);
         re_in[i]  = mq(r_ff[i], coef_ff[4 + i]);
         pj_in[i]  = mq(r_ff[j], coef_ff[k]);
         pk_in[i]  = mq(r_ff[k], coef_ff[j]);
         // cross product
         cr_in[i]  = pj_ff[i] - pk_ff[i];
         // second products
         ae_in[i]  = mq(a2_ff, coef_ff[4 + i]);
         cs_in[i]  = mq(cr_ff[i], coef_ff[7]);
         // recombine, translate back and saturate; a null axis passes the point through
         sum = PW'(center_ff[i]) + ra4_ff[i] + (ae_ff[i] <<< 1) - cs_ff[i];
         if (nul_ff[3]) begin
            o_in[i] = p4_ff[i];
         end else if (sum > SAT_HI) begin
            o_in[i] = SAT_HI[COORD_BITS-1:0];
         end else if (sum < SAT_LO) begin
            o_in[i] = SAT_LO[COORD_BITS-1:0];
         end else begin
            o_in[i] = sum[COORD_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p1_ff   <= p_in;
         r_ff    <= r_in;
         p2_ff   <= p1_ff;
         ra2_ff  <= ra2_in;
         re_ff   <= re_in;
         pj_ff   <= pj_in;
         pk_ff   <= pk_in;
         p3_ff   <= p2_ff;
         ra3_ff  <= ra2_ff;
         a2_ff   <= a2_in;
         cr_ff   <= cr_in;
         p4_ff   <= p3_ff;
         ra4_ff  <= ra3_ff;
         ae_ff   <= ae_in;
         cs_ff   <= cs_in;
         o_ff    <= o_in;
         last_ff <= {last_ff[3:0], req_last_in};
         nul_ff  <= {nul_ff[3:0], null_axis};
      end
   end

   assign rsp_valid     = v5_ff;
   assign rsp_px_out    = o_ff[0];
   assign rsp_py_out    = o_ff[1];
   assign rsp_pz_out    = o_ff[2];
   assign rsp_null_axis = nul_ff[4];
   assign rsp_last_out  = last_ff[4];

   // a register write blocks input on the following cycle
   a_cfg_blocks: assert property (@(posedge clock) disable iff (reset)
      (csr_we && (csr_index <= prot_pkg::REG_AXIS_Z)) |=> req_stall)
      else $error("input accepted while coefficients are stale");

   // coefficients only change while the sequencer runs
   a_coef_stable: assert property (@(posedge clock) disable iff (reset)
      (state_ff == prot_pkg::SEQ_IDLE) |=> $stable(coef_ff[3]) && $stable(coef_ff[7]))
      else $error("coefficients changed outside the sequencer");

   // an output beat comes only from a valid fourth stage
   a_out_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(v4_ff))
      else $error("output beat without a source");

endmodule
